@@ rtl/core/tmpe_pkg.sv @@
package tmpe_pkg;

  // Configuration register file.
  localparam int CAP_W     = 17;
  localparam int CFG_IDX_W = 1;
  localparam logic [CAP_W-1:0] CAP_RESET = 17'd4096;
  localparam logic [CFG_IDX_W-1:0] REG_MODE     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 1'b1;

  localparam logic MODE_PATH      = 1'b0;
  localparam logic MODE_COMPONENT = 1'b1;

  // Depth of the queue between the classifier and the encoder.
  localparam int QUEUE_DEPTH = 2;

  // Characters of interest.
  localparam logic [7:0] CHAR_NUL        = 8'h00;
  localparam logic [7:0] CHAR_PERCENT    = 8'h25;
  localparam logic [7:0] CHAR_DASH       = 8'h2D;
  localparam logic [7:0] CHAR_DOT        = 8'h2E;
  localparam logic [7:0] CHAR_SLASH      = 8'h2F;
  localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;

  // UTF-8 lead and continuation ranges.
  localparam logic [7:0] CONT_LO   = 8'h80;
  localparam logic [7:0] CONT_HI   = 8'hBF;
  localparam logic [7:0] LEAD2_LO  = 8'hC2;
  localparam logic [7:0] LEAD2_HI  = 8'hDF;
  localparam logic [7:0] LEAD3_LO  = 8'hE0;
  localparam logic [7:0] LEAD3_HI  = 8'hEF;
  localparam logic [7:0] LEAD4_LO  = 8'hF0;
  localparam logic [7:0] LEAD4_HI  = 8'hF4;
  localparam logic [7:0] LEAD_E0   = 8'hE0;
  localparam logic [7:0] LEAD_ED   = 8'hED;
  localparam logic [7:0] LEAD_F0   = 8'hF0;
  localparam logic [7:0] LEAD_F4   = 8'hF4;
  localparam logic [7:0] E0_SEC_LO = 8'hA0;
  localparam logic [7:0] ED_SEC_HI = 8'h9F;
  localparam logic [7:0] F0_SEC_LO = 8'h90;
  localparam logic [7:0] F4_SEC_HI = 8'h8F;

  localparam logic [7:0] HEX_DIGITS [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
  };

  typedef struct packed {
    logic safe_path;
    logic safe_comp;
    logic is_dot;
  } byte_class_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    byte_class_t cls;
  } item_t;

  function automatic byte_class_t classify(input logic [7:0] c);
    byte_class_t r;
    logic alnum;
    logic base;
    alnum = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
            (c >= 8'h61 && c <= 8'h7A);
    base  = alnum || c == CHAR_DOT || c == CHAR_UNDERSCORE || c == CHAR_DASH;
    r.safe_path = base || c == CHAR_SLASH;
    r.safe_comp = base;
    r.is_dot    = (c == CHAR_DOT);
    return r;
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    return HEX_DIGITS[v];
  endfunction

  // Length of the sequence that a lead byte opens, zero if it opens none.
  function automatic logic [2:0] utf8_need(input logic [7:0] lead);
    logic [2:0] r;
    r = 3'd0;
    if (lead >= LEAD2_LO && lead <= LEAD2_HI) r = 3'd2;
    if (lead >= LEAD3_LO && lead <= LEAD3_HI) r = 3'd3;
    if (lead >= LEAD4_LO && lead <= LEAD4_HI) r = 3'd4;
    return r;
  endfunction

  function automatic logic [7:0] second_lo(input logic [7:0] lead);
    logic [7:0] r;
    r = CONT_LO;
    if (lead == LEAD_E0) r = E0_SEC_LO;
    if (lead == LEAD_F0) r = F0_SEC_LO;
    return r;
  endfunction

  function automatic logic [7:0] second_hi(input logic [7:0] lead);
    logic [7:0] r;
    r = CONT_HI;
    if (lead == LEAD_ED) r = ED_SEC_HI;
    if (lead == LEAD_F4) r = F4_SEC_HI;
    return r;
  endfunction

endpackage

@@ rtl/core/tmpe_front.sv @@
module tmpe_front
  import tmpe_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       push_valid,
  input  logic       push_ready,
  output item_t      push_item
);

  logic  stage_valid;
  item_t stage;

  assign in_ready   = !stage_valid || push_ready;
  assign push_valid = stage_valid;
  assign push_item  = stage;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  // The byte class is worked out once here so the encoder only selects it.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage.data <= in_byte;
      stage.last <= in_last;
      stage.cls  <= classify(in_byte);
    end
  end

endmodule

@@ rtl/core/tmpe_queue.sv @@
module tmpe_queue
  import tmpe_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push_valid,
  output logic  push_ready,
  input  item_t push_item,
  output logic  head_valid,
  input  logic  head_pop,
  output item_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  item_t            mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = head_pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

@@ rtl/core/tmpe_back.sv @@
module tmpe_back
  import tmpe_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             mode,
  input  logic [CAP_W-1:0] cap,
  input  logic             head_valid,
  input  item_t            head,
  output logic             head_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_char,
  output logic             out_last,
  output logic             overflow
);

  // Bytes of an unfinished UTF-8 sequence carried over from earlier words.
  logic [7:0]       held [3];
  logic [1:0]       cnt;
  logic [1:0]       pos;
  logic [1:0]       sub;
  logic             esc_unit;
  logic [7:0]       esc_byte;
  logic [CAP_W-1:0] emitted;
  logic             failed;

  logic [7:0]  bv [4];
  logic [7:0]  shifted [3];
  logic [2:0]  pos3;
  logic [2:0]  n;
  logic [2:0]  avail;
  logic [7:0]  c;
  byte_class_t cls_c;
  logic [2:0]  need;
  logic [2:0]  chk;
  logic        prefix_ok;
  logic        esc;
  logic        hold;
  logic [2:0]  take;
  logic [2:0]  size;
  logic        fits;
  logic        out_free;
  logic        deciding;
  logic        do_drop;
  logic        do_hold;
  logic        do_ovf;
  logic        do_first;
  logic        do_cont;
  logic        step_end;
  logic [7:0]  cont_char;

  // The working buffer is the held bytes with the queue head appended.
  always_comb begin
    bv[0] = (cnt == 2'd0) ? head.data : held[0];
    bv[1] = (cnt == 2'd1) ? head.data : held[1];
    bv[2] = (cnt == 2'd2) ? head.data : held[2];
    bv[3] = head.data;
    for (int i = 0; i < 3; i++) begin
      shifted[i] = bv[pos + 2'(i)];
    end
  end

  assign pos3  = {1'b0, pos};
  assign n     = {1'b0, cnt} + 3'd1;
  assign avail = n - pos3;
  assign c     = bv[pos];
  // Held bytes are all at or above 0x80, so only the new byte has a class.
  assign cls_c = (pos == cnt) ? head.cls : '0;
  assign need  = utf8_need(c);
  assign chk   = (avail < need) ? avail : need;

  always_comb begin
    logic [2:0] idx;
    logic [7:0] b;
    logic [7:0] lo;
    logic [7:0] hi;
    prefix_ok = 1'b1;
    for (int j = 1; j < 4; j++) begin
      idx = pos3 + 3'(j);
      b   = bv[idx[1:0]];
      lo  = (j == 1) ? second_lo(c) : CONT_LO;
      hi  = (j == 1) ? second_hi(c) : CONT_HI;
      if (3'(j) < chk && (b < lo || b > hi)) begin
        prefix_ok = 1'b0;
      end
    end
  end

  always_comb begin
    esc  = 1'b0;
    hold = 1'b0;
    take = 3'd1;
    if (mode == MODE_PATH) begin
      esc = !cls_c.safe_path;
    end else if (!c[7]) begin
      esc = !cls_c.safe_comp || (cls_c.is_dot && head.last && pos == cnt);
    end else if (need == 3'd0 || !prefix_ok) begin
      esc = 1'b1;
    end else if (avail >= need) begin
      take = need;
    end else if (head.last) begin
      esc = 1'b1;
    end else begin
      hold = 1'b1;
    end
  end

  assign size = esc ? 3'd3 : take;
  assign fits = ({1'b0, emitted} + (CAP_W + 1)'(size)) < {1'b0, cap};

  assign out_free = !out_valid || out_ready;
  assign deciding = head_valid && !failed && sub == 2'd0;
  assign do_drop  = head_valid && failed;
  assign do_hold  = deciding && hold;
  assign do_ovf   = deciding && !hold && out_free && !fits;
  assign do_first = deciding && !hold && out_free && fits;
  assign do_cont  = head_valid && !failed && sub != 2'd0 && out_free;
  assign step_end = (do_first && !esc && take == 3'd1 && pos == cnt) ||
                    (do_cont && sub == 2'd1 && pos == cnt);
  assign head_pop = do_drop || do_hold || do_ovf || step_end;

  always_comb begin
    if (!esc_unit) begin
      cont_char = c;
    end else if (sub == 2'd2) begin
      cont_char = hex_digit(esc_byte[7:4]);
    end else begin
      cont_char = hex_digit(esc_byte[3:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      pos       <= '0;
      sub       <= '0;
      esc_unit  <= 1'b0;
      emitted   <= '0;
      failed    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (do_drop && head.last) begin
        failed  <= 1'b0;
        emitted <= '0;
        cnt     <= '0;
      end
      if (do_hold) begin
        cnt <= avail[1:0];
        pos <= '0;
      end
      if (do_ovf) begin
        out_valid <= 1'b1;
        out_char  <= CHAR_NUL;
        out_last  <= 1'b1;
        overflow  <= 1'b1;
        failed    <= !head.last;
        cnt       <= '0;
        pos       <= '0;
        if (head.last) begin
          emitted <= '0;
        end
      end
      if (do_first) begin
        out_valid <= 1'b1;
        out_char  <= esc ? CHAR_PERCENT : c;
        out_last  <= step_end && head.last;
        overflow  <= 1'b0;
        emitted   <= emitted + CAP_W'(size);
        esc_unit  <= esc;
        esc_byte  <= c;
        sub       <= esc ? 2'd2 : 2'(take - 3'd1);
        if (!esc) begin
          pos <= pos + 2'd1;
        end
      end
      if (do_cont) begin
        out_valid <= 1'b1;
        out_char  <= cont_char;
        out_last  <= step_end && head.last;
        overflow  <= 1'b0;
        sub       <= sub - 2'd1;
        if (!esc_unit || sub == 2'd1) begin
          pos <= pos + 2'd1;
        end
      end
      // A word is finished once its final character is on its way out.
      if (step_end) begin
        cnt <= '0;
        pos <= '0;
        if (head.last) begin
          emitted <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_hold) begin
      for (int i = 0; i < 3; i++) begin
        if (3'(i) < avail) begin
          held[i] <= shifted[i];
        end
      end
    end
  end

  a_pos_in_buffer: assert property (@(posedge clk) disable iff (rst)
    pos <= cnt)
    else $error("scan position has run past the buffered bytes");

  a_failed_is_clean: assert property (@(posedge clk) disable iff (rst)
    failed |-> (cnt == 2'd0 && sub == 2'd0))
    else $error("bytes held or unit open while dropping a failed string");

  a_unit_has_word: assert property (@(posedge clk) disable iff (rst)
    (sub != 2'd0) |-> head_valid)
    else $error("unit in progress without its word at the queue head");

  a_error_item_shape: assert property (@(posedge clk) disable iff (rst)
    (out_valid && overflow) |-> (out_last && out_char == CHAR_NUL))
    else $error("error word is not a terminating null");

endmodule

@@ rtl/core/two_mode_percent_encoder.sv @@
// An accepted word is registered in the front stage and the queue before its first
// character is registered at the output. Throughput: one character per cycle while
// out_ready is high; a passed byte gives one character, an escaped byte three, and
// a held or dropped byte none. The one output character register sets the rate.
// Reset: synchronous, active high; clears the queue, held count, character count
// and failure flag, and sets mode 0 and an output capacity of 4096.
module two_mode_percent_encoder
  import tmpe_pkg::*;
#(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_byte,
  input  logic                 in_last,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_char,
  output logic                 out_last,
  output logic                 overflow,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CAP_W-1:0]     cfg_data
);

  logic             mode;
  logic [CAP_W-1:0] out_capacity;
  logic             push_valid;
  logic             push_ready;
  item_t            push_item;
  logic             head_valid;
  logic             head_pop;
  item_t            head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_PATH;
      out_capacity <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MODE:     mode         <= cfg_data[0];
        REG_CAPACITY: out_capacity <= cfg_data;
        default: ;
      endcase
    end
  end

  tmpe_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .in_last    (in_last),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  tmpe_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .head_valid (head_valid),
    .head_pop   (head_pop),
    .head       (head)
  );

  tmpe_back u_back (
    .clk        (clk),
    .rst        (rst),
    .mode       (mode),
    .cap        (out_capacity),
    .head_valid (head_valid),
    .head       (head),
    .head_pop   (head_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_char   (out_char),
    .out_last   (out_last),
    .overflow   (overflow)
  );

endmodule

@@ tb/encoder_checker.sv @@
module encoder_checker
  import tmpe_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [7:0]           in_byte,
  input  logic                 in_last,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [7:0]           out_char,
  input  logic                 out_last,
  input  logic                 overflow,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CAP_W-1:0]     cfg_data,
  output int                   fail_count,
  output int                   pending,
  output int                   chars_checked,
  output int                   overflow_words
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       ovf;
  } enc_char_t;

  enc_char_t        enc_expected [$];
  enc_char_t        want;
  logic             cur_mode;
  logic [CAP_W-1:0] cur_cap;
  logic [7:0]       held [0:2];
  int               held_n;
  int               emitted;
  bit               dropping;

  function automatic bit plain_char(input logic [7:0] c, input bit slash_ok);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A) || c == CHAR_DOT || c == CHAR_UNDERSCORE ||
           c == CHAR_DASH || (slash_ok && c == CHAR_SLASH);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? 8'h30 + 8'(n) : 8'h37 + 8'(n);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    fail_count++;
  endtask

  // Works out the characters that one accepted input word gives rise to.
  task automatic encode_byte(input logic [7:0] b, input logic l);
    logic [7:0] seq_bytes [0:6];
    enc_char_t  step_out [0:11];
    logic [7:0] c, lo, hi;
    int         n, pos, i, need, avail, chk, take, size, k;
    bit         esc, holding, quit, ok;
    if (dropping) begin
      if (l) begin
        dropping = 1'b0;
        emitted  = 0;
        held_n   = 0;
      end
      return;
    end
    for (i = 0; i < 7; i++) seq_bytes[i] = 8'h00;
    n = 0;
    for (i = 0; i < held_n; i++) begin
      seq_bytes[n] = held[i];
      n++;
    end
    seq_bytes[n] = b;
    n++;
    pos = 0;
    k = 0;
    holding = 1'b0;
    quit = 1'b0;
    while (pos < n && !quit && !holding) begin
      c = seq_bytes[pos];
      take = 1;
      esc = 1'b0;
      if (cur_mode == MODE_PATH) begin
        esc = !plain_char(c, 1'b1);
      end else if (c < CONT_LO) begin
        esc = !plain_char(c, 1'b0) || (c == CHAR_DOT && l && pos + 1 == n);
      end else begin
        need = 0;
        if (c >= LEAD2_LO && c <= LEAD2_HI) need = 2;
        if (c >= LEAD3_LO && c <= LEAD3_HI) need = 3;
        if (c >= LEAD4_LO && c <= LEAD4_HI) need = 4;
        avail = n - pos;
        chk = (avail < need) ? avail : need;
        ok = 1'b1;
        for (i = 1; i < chk; i++) begin
          lo = CONT_LO;
          hi = CONT_HI;
          if (i == 1) begin
            if (c == LEAD_E0) lo = E0_SEC_LO;
            if (c == LEAD_F0) lo = F0_SEC_LO;
            if (c == LEAD_ED) hi = ED_SEC_HI;
            if (c == LEAD_F4) hi = F4_SEC_HI;
          end
          if (seq_bytes[pos+i] < lo || seq_bytes[pos+i] > hi) ok = 1'b0;
        end
        if (need == 0 || !ok) begin
          esc = 1'b1;
        end else if (avail >= need) begin
          take = need;
        end else if (l) begin
          esc = 1'b1;
        end else begin
          // An unfinished but plausible sequence waits for its next byte.
          held_n = avail;
          for (i = 0; i < avail; i++) held[i] = seq_bytes[pos+i];
          holding = 1'b1;
        end
      end
      if (!holding) begin
        size = esc ? 3 : take;
        if (emitted + size >= int'(cur_cap)) begin
          step_out[k] = {CHAR_NUL, 1'b1, 1'b1};
          k++;
          held_n = 0;
          if (l) begin
            emitted  = 0;
            dropping = 1'b0;
          end else begin
            dropping = 1'b1;
          end
          quit = 1'b1;
        end else begin
          if (esc) begin
            step_out[k]   = {CHAR_PERCENT, 1'b0, 1'b0};
            step_out[k+1] = {hex_char(c[7:4]), 1'b0, 1'b0};
            step_out[k+2] = {hex_char(c[3:0]), 1'b0, 1'b0};
            k += 3;
          end else begin
            for (i = 0; i < take; i++) begin
              step_out[k] = {seq_bytes[pos+i], 1'b0, 1'b0};
              k++;
            end
          end
          emitted += size;
          pos += take;
        end
      end
    end
    if (!quit) begin
      if (!holding) held_n = 0;
      if (l) begin
        if (k > 0) step_out[k-1].last = 1'b1;
        emitted = 0;
        held_n  = 0;
      end
    end
    for (i = 0; i < k; i++) enc_expected.push_back(step_out[i]);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cur_mode       = MODE_PATH;
      cur_cap        = CAP_RESET;
      held_n         = 0;
      emitted        = 0;
      dropping       = 1'b0;
      fail_count     = 0;
      chars_checked  = 0;
      overflow_words = 0;
      enc_expected.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_MODE) cur_mode = cfg_data[0];
        else if (cfg_index == REG_CAPACITY) cur_cap = cfg_data;
      end
      if (out_valid && out_ready) begin
        chars_checked++;
        if (overflow === 1'b1) overflow_words++;
        if (enc_expected.size() == 0) begin
          report_mismatch($sformatf("word with nothing expected: char %02h last %b overflow %b",
                                    out_char, out_last, overflow));
        end else begin
          want = enc_expected.pop_front();
          if (out_char !== want.ch || out_last !== want.last || overflow !== want.ovf)
            report_mismatch($sformatf(
              "word %0d: char %02h last %b overflow %b, expected %02h %b %b",
              chars_checked, out_char, out_last, overflow, want.ch, want.last, want.ovf));
        end
      end
      if (in_valid && in_ready) encode_byte(in_byte, in_last);
    end
    pending <= enc_expected.size();
  end

endmodule

@@ tb/tb.sv @@
module tb
  import tmpe_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD     = 10;
  localparam int SETTLE_CYCLES  = 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_BYTES    = 26;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  logic [7:0]           in_byte   = 8'h41;
  logic                 in_last   = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [7:0]           out_char;
  logic                 out_last;
  logic                 overflow;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_MODE;
  logic [CAP_W-1:0]     cfg_data  = '0;

  int fail_count, pending, chars_checked, overflow_words;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int bytes_sent     = 0;
  int strings_sent   = 0;
  int settings_used  = 0;
  int idle_cycles    = 0;

  logic [7:0] text [$];

  two_mode_percent_encoder dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_byte(in_byte), .in_last(in_last),
    .out_valid(out_valid), .out_ready(out_ready), .out_char(out_char),
    .out_last(out_last), .overflow(overflow),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  encoder_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_byte(in_byte), .in_last(in_last),
    .out_valid(out_valid), .out_ready(out_ready), .out_char(out_char),
    .out_last(out_last), .overflow(overflow),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending), .chars_checked(chars_checked),
    .overflow_words(overflow_words)
  );

  always #(CLK_PERIOD/2) clk = ~clk;

  always @(posedge clk) out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Timed out: no word moved for %0d cycles.", WATCHDOG_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  // This task lowers valid only in its idle loop, so back-to-back words keep it high.
  task automatic send_byte(input logic [7:0] b, input logic l);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= l;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    if (l) strings_sent++;
  endtask

  task automatic wait_quiet();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes both registers back to back; the mode word carries junk in its upper bits.
  task automatic load_config(input logic m, input int unsigned cap);
    logic [CAP_W-2:0] junk;
    junk = (CAP_W-1)'($urandom_range(0, 65535));
    cfg_valid <= 1'b1;
    cfg_index <= REG_MODE;
    cfg_data  <= {junk, m};
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_CAPACITY;
    cfg_data  <= cap[CAP_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic send_text();
    int i;
    for (i = 0; i < text.size(); i++) begin
      if (i > 0 && $urandom_range(0, 39) == 0) wait_quiet();
      send_byte(text[i], i == text.size() - 1);
    end
  endtask

  task automatic add_unit();
    int         kind, len, brk, i;
    logic [7:0] lead, lo, hi;
    bit         cut;
    kind = $urandom_range(0, 9);
    case (kind) inside
      [0:2]: begin
        i = $urandom_range(0, 65);
        if (i < 10) text.push_back(8'(8'h30 + i));
        else if (i < 36) text.push_back(8'(8'h41 + i - 10));
        else if (i < 62) text.push_back(8'(8'h61 + i - 36));
        else if (i == 62) text.push_back(CHAR_DOT);
        else if (i == 63) text.push_back(CHAR_UNDERSCORE);
        else if (i == 64) text.push_back(CHAR_DASH);
        else text.push_back(CHAR_SLASH);
      end
      3: text.push_back(8'($urandom_range(1, 127)));
      [4:7]: begin
        len = $urandom_range(2, 4);
        if (len == 2) lead = 8'($urandom_range(LEAD2_LO, LEAD2_HI));
        else if (len == 3) lead = 8'($urandom_range(LEAD3_LO, LEAD3_HI));
        else lead = 8'($urandom_range(LEAD4_LO, LEAD4_HI));
        // Bias towards the leads whose second byte has a narrowed range.
        if (len > 2 && $urandom_range(0, 2) == 0) begin
          if (len == 3) lead = $urandom_range(0, 1) ? LEAD_E0 : LEAD_ED;
          else lead = $urandom_range(0, 1) ? LEAD_F0 : LEAD_F4;
        end
        lo = CONT_LO;
        hi = CONT_HI;
        if (lead == LEAD_E0) lo = E0_SEC_LO;
        if (lead == LEAD_F0) lo = F0_SEC_LO;
        if (lead == LEAD_ED) hi = ED_SEC_HI;
        if (lead == LEAD_F4) hi = F4_SEC_HI;
        brk = (kind == 7) ? $urandom_range(1, len - 1) : len;
        text.push_back(lead);
        cut = 1'b0;
        for (i = 1; i < len && !cut; i++) begin
          if (i == brk) begin
            case ($urandom_range(0, 3))
              0: text.push_back(8'($urandom_range(1, 127)));
              1: text.push_back(8'($urandom_range(8'hC0, 8'hFF)));
              2: begin
                if (i == 1 && lo != CONT_LO) text.push_back(8'($urandom_range(CONT_LO, lo - 1)));
                else if (i == 1 && hi != CONT_HI)
                  text.push_back(8'($urandom_range(hi + 1, CONT_HI)));
                else text.push_back(8'($urandom_range(8'hC0, 8'hFF)));
              end
              default: ;
            endcase
            cut = 1'b1;
          end else if (i == 1) begin
            text.push_back(8'($urandom_range(lo, hi)));
          end else begin
            text.push_back(8'($urandom_range(CONT_LO, CONT_HI)));
          end
        end
      end
      8: text.push_back(8'($urandom_range(8'h80, 8'hFF)));
      default: text.push_back(8'($urandom_range(1, 255)));
    endcase
  endtask

  initial begin
    int phase, quota, units;
    int unsigned cap;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: path mode, default capacity.
    text = '{8'h01, CHAR_SLASH, 8'h7A, 8'hFF};
    send_text();

    wait_quiet();
    load_config(MODE_COMPONENT, CAP_RESET);
    // Slash is escaped, and so is a dot that ends the string.
    text = '{CHAR_SLASH, CHAR_DOT};
    send_text();
    // A whole three-byte sequence, then a lead cut short by the end of the string.
    text = '{8'hE2, 8'h82, 8'hAC, 8'hC3};
    send_text();
    // Second byte outside the narrowed range for this lead.
    text = '{8'hE0, 8'h9F};
    send_text();

    // Held prefix, then the mode switches to path before the sequence completes.
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b0);
    wait_quiet();
    load_config(MODE_PATH, CAP_RESET);
    send_byte(8'hAC, 1'b1);

    wait_quiet();
    load_config(MODE_PATH, 1);
    text = '{8'h61, 8'h62};
    send_text();

    wait_quiet();
    load_config(MODE_PATH, 0);
    text = '{8'h61};
    send_text();

    wait_quiet();
    load_config(MODE_COMPONENT, 131071);
    text = '{8'hF0, 8'h9F, 8'h98, 8'h80};
    send_text();

    // Two characters fit, the escape that follows does not.
    wait_quiet();
    load_config(MODE_COMPONENT, 5);
    text = '{8'h61, 8'h62, 8'h20};
    send_text();

    for (phase = 0; phase < 8; phase++) begin
      case (phase) inside
        0, 7:    cap = 65536;
        [1:2]:   cap = $urandom_range(4, 30);
        [3:4]:   cap = CAP_RESET;
        default: cap = $urandom_range(12, 48);
      endcase
      wait_quiet();
      load_config(phase[0], cap);
      case (phase / 2)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      quota = bytes_sent + PHASE_BYTES;
      while (bytes_sent < quota) begin
        text.delete();
        units = $urandom_range(1, 6);
        repeat (units) add_unit();
        send_text();
      end
    end

    wait_quiet();
    $display("Run covered %0d bytes in %0d strings under %0d register settings,", bytes_sent,
             strings_sent, settings_used);
    $display("with %0d characters checked, %0d of them overflow words.", chars_checked,
             overflow_words);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches.", fail_count);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
